>>> rtl/core/ohlc_pkg.sv
package ohlc_pkg;

   // Field widths
   localparam int CmdW    = 1;
   localparam int PriceW  = 48;
   localparam int TimeW   = 48;
   localparam int SumW    = 64;
   localparam int CountW  = 32;
   localparam int DurW    = 32;

   // Divider step counter indexes one timestamp bit
   localparam int BitCntW = $clog2(TimeW);

   // First timestamp bit the divider shifts in
   localparam logic [BitCntW-1:0] LastBit = BitCntW'(TimeW - 1);

   localparam logic [DurW-1:0] DUR_RESET = DurW'(60);

   // Request commands
   localparam logic [CmdW-1:0] CMD_TRADE = 1'b0;
   localparam logic [CmdW-1:0] CMD_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ALIGN,
      ST_COMMIT
   } ohlc_state_type;

   typedef struct packed {
      logic req_ready;
      logic div_step;
      logic align_step;
      logic commit_step;
   } ohlc_ctrl_type;

endpackage

>>> rtl/core/ohlc_chan_if.sv
interface ohlc_req_if;
   logic                            valid;
   logic                            ready;
   logic [ohlc_pkg::CmdW-1:0]       cmd;
   logic [ohlc_pkg::PriceW-1:0]     price;
   logic [ohlc_pkg::TimeW-1:0]      timestamp;

   modport source (output valid, cmd, price, timestamp, input ready);
   modport sink   (input valid, cmd, price, timestamp, output ready);
endinterface

interface ohlc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ohlc_pkg::TimeW-1:0]      bar_start;
   logic [ohlc_pkg::PriceW-1:0]     open_price;
   logic [ohlc_pkg::PriceW-1:0]     high_price;
   logic [ohlc_pkg::PriceW-1:0]     low_price;
   logic [ohlc_pkg::PriceW-1:0]     close_price;
   logic [ohlc_pkg::SumW-1:0]       price_total;
   logic [ohlc_pkg::CountW-1:0]     trades;

   modport source (output valid, bar_start, open_price, high_price, low_price, close_price,
                   price_total, trades, input ready);
   modport sink   (input valid, bar_start, open_price, high_price, low_price, close_price,
                   price_total, trades, output ready);
endinterface

>>> rtl/core/ohlc_bar_aggregator.sv
// OHLC bar aggregator. Each trade request runs from its acceptance through 48 steps of a
// restoring divider that reduces the 48-bit timestamp modulo the bucket duration one bit per
// cycle, one step to align the start and one step to update or seal the open bar; no new
// request is taken until it is done. A flush request skips the divider and the align step.
// The commit step waits, when it must seal a bar, while an earlier sealed bar still sits
// unclaimed in the output register; that register otherwise lets the next request in while a
// bar waits to be taken. A zero bucket duration acts as a duration of one. The duration
// register is written through csr_wr_en and csr_wr_data and resets to 60.
module ohlc_bar_aggregator (
   input  logic                         clock,
   input  logic                         reset,
   ohlc_req_if.sink                     req_chan,
   ohlc_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [ohlc_pkg::DurW-1:0]    csr_wr_data
);

   ohlc_pkg::ohlc_state_type state_ff, state_in;
   ohlc_pkg::ohlc_ctrl_type  ctrl;

   logic [ohlc_pkg::DurW-1:0]    dur_ff;
   logic [ohlc_pkg::CmdW-1:0]    cmd_ff;
   logic [ohlc_pkg::PriceW-1:0]  price_ff;
   logic [ohlc_pkg::TimeW-1:0]   ts_ff;
   logic [ohlc_pkg::BitCntW-1:0] bit_cnt_ff;
   logic [ohlc_pkg::DurW-1:0]    rem_ff, rem_in;
   logic [ohlc_pkg::TimeW-1:0]   start_ff;

   logic                         bar_open_ff;
   logic [ohlc_pkg::TimeW-1:0]   cur_start_ff;
   logic [ohlc_pkg::PriceW-1:0]  cur_open_ff;
   logic [ohlc_pkg::PriceW-1:0]  cur_high_ff;
   logic [ohlc_pkg::PriceW-1:0]  cur_low_ff;
   logic [ohlc_pkg::PriceW-1:0]  cur_close_ff;
   logic [ohlc_pkg::SumW-1:0]    cur_sum_ff, sum_in;
   logic [ohlc_pkg::CountW-1:0]  cur_count_ff, count_in;

   logic                         rsp_valid_ff;
   logic [ohlc_pkg::TimeW-1:0]   rsp_start_ff;
   logic [ohlc_pkg::PriceW-1:0]  rsp_open_ff;
   logic [ohlc_pkg::PriceW-1:0]  rsp_high_ff;
   logic [ohlc_pkg::PriceW-1:0]  rsp_low_ff;
   logic [ohlc_pkg::PriceW-1:0]  rsp_close_ff;
   logic [ohlc_pkg::SumW-1:0]    rsp_sum_ff;
   logic [ohlc_pkg::CountW-1:0]  rsp_count_ff;

   logic [ohlc_pkg::DurW-1:0]    dur_eff;
   logic [ohlc_pkg::DurW:0]      rem_shift;
   logic [ohlc_pkg::DurW:0]      rem_diff;
   logic [ohlc_pkg::SumW:0]      sum_wide;
   logic                         is_flush;
   logic                         emit_need;
   logic                         out_blocked;
   logic                         req_fire;

   // Divider step: shift in one timestamp bit, subtract if it fits
   always_comb begin
      dur_eff   = (dur_ff == '0) ? ohlc_pkg::DurW'(1) : dur_ff;
      rem_shift = {rem_ff, ts_ff[bit_cnt_ff]};
      rem_diff  = rem_shift - {1'b0, dur_eff};
      rem_in    = (rem_shift >= {1'b0, dur_eff}) ? rem_diff[ohlc_pkg::DurW-1:0]
                                                 : rem_shift[ohlc_pkg::DurW-1:0];
   end

   // Saturating sum and count for a trade in the open bucket
   always_comb begin
      sum_wide = {1'b0, cur_sum_ff} + {{(ohlc_pkg::SumW - ohlc_pkg::PriceW + 1){1'b0}}, price_ff};
      sum_in   = sum_wide[ohlc_pkg::SumW] ? '1 : sum_wide[ohlc_pkg::SumW-1:0];
      count_in = (cur_count_ff == '1) ? cur_count_ff : cur_count_ff + ohlc_pkg::CountW'(1);
   end

   // Decide whether the commit step seals a bar and whether it must wait
   always_comb begin
      is_flush    = (cmd_ff == ohlc_pkg::CMD_FLUSH);
      emit_need   = bar_open_ff && (is_flush || (start_ff != cur_start_ff));
      out_blocked = emit_need && rsp_valid_ff && !rsp_chan.ready;
      req_fire    = req_chan.valid && ctrl.req_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ohlc_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.cmd == ohlc_pkg::CMD_FLUSH) ? ohlc_pkg::ST_COMMIT
                                                                : ohlc_pkg::ST_DIVIDE;
            end
         end
         ohlc_pkg::ST_DIVIDE: begin
            if (bit_cnt_ff == '0) state_in = ohlc_pkg::ST_ALIGN;
         end
         ohlc_pkg::ST_ALIGN: begin
            state_in = ohlc_pkg::ST_COMMIT;
         end
         ohlc_pkg::ST_COMMIT: begin
            if (!out_blocked) state_in = ohlc_pkg::ST_IDLE;
         end
         default: state_in = ohlc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ohlc_pkg::ST_IDLE:   ctrl.req_ready   = 1'b1;
         ohlc_pkg::ST_DIVIDE: ctrl.div_step    = 1'b1;
         ohlc_pkg::ST_ALIGN:  ctrl.align_step  = 1'b1;
         ohlc_pkg::ST_COMMIT: ctrl.commit_step = !out_blocked;
         default:             ctrl = '0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ohlc_pkg::ST_IDLE;
         dur_ff       <= ohlc_pkg::DUR_RESET;
         bar_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) dur_ff <= csr_wr_data;
         // Drop the result once taken, raise it when a bar is sealed
         if (ctrl.commit_step && emit_need) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctrl.commit_step) begin
            if (is_flush) bar_open_ff <= 1'b0;
            else          bar_open_ff <= 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      // Capture the request
      if (req_fire) begin
         cmd_ff     <= req_chan.cmd;
         price_ff   <= req_chan.price;
         ts_ff      <= req_chan.timestamp;
         bit_cnt_ff <= ohlc_pkg::LastBit;
         rem_ff     <= '0;
      end
      // Advance the divider
      if (ctrl.div_step) begin
         rem_ff     <= rem_in;
         bit_cnt_ff <= bit_cnt_ff - ohlc_pkg::BitCntW'(1);
      end
      // Align the timestamp down to the bucket
      if (ctrl.align_step) begin
         start_ff <= ts_ff - {{(ohlc_pkg::TimeW - ohlc_pkg::DurW){1'b0}}, rem_ff};
      end
      // Seal the open bar into the output register
      if (ctrl.commit_step && emit_need) begin
         rsp_start_ff <= cur_start_ff;
         rsp_open_ff  <= cur_open_ff;
         rsp_high_ff  <= cur_high_ff;
         rsp_low_ff   <= cur_low_ff;
         rsp_close_ff <= cur_close_ff;
         rsp_sum_ff   <= cur_sum_ff;
         rsp_count_ff <= cur_count_ff;
      end
      // Update or reopen the bar on a trade
      if (ctrl.commit_step && !is_flush) begin
         if (bar_open_ff && !emit_need) begin
            if (price_ff > cur_high_ff) cur_high_ff <= price_ff;
            if (price_ff < cur_low_ff)  cur_low_ff  <= price_ff;
            cur_close_ff <= price_ff;
            cur_sum_ff   <= sum_in;
            cur_count_ff <= count_in;
         end else begin
            cur_start_ff <= start_ff;
            cur_open_ff  <= price_ff;
            cur_high_ff  <= price_ff;
            cur_low_ff   <= price_ff;
            cur_close_ff <= price_ff;
            cur_sum_ff   <= {{(ohlc_pkg::SumW - ohlc_pkg::PriceW){1'b0}}, price_ff};
            cur_count_ff <= ohlc_pkg::CountW'(1);
         end
      end
   end

   // Drive the channels
   assign req_chan.ready       = ctrl.req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bar_start   = rsp_start_ff;
   assign rsp_chan.open_price  = rsp_open_ff;
   assign rsp_chan.high_price  = rsp_high_ff;
   assign rsp_chan.low_price   = rsp_low_ff;
   assign rsp_chan.close_price = rsp_close_ff;
   assign rsp_chan.price_total = rsp_sum_ff;
   assign rsp_chan.trades      = rsp_count_ff;

   // A result only appears out of the commit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ohlc_pkg::ST_COMMIT))
      else $error("result raised outside the commit step");

   // An open bar holds at least one trade and a sane price range
   assert property (@(posedge clock) disable iff (reset)
      bar_open_ff |-> (cur_count_ff != '0) && (cur_low_ff <= cur_high_ff))
      else $error("open bar holds an inconsistent count or range");

   // The divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ohlc_pkg::ST_ALIGN) |-> (rem_ff < dur_eff))
      else $error("remainder not reduced below the bucket duration");

   // A blocked commit never overwrites a waiting result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ohlc_pkg::ST_COMMIT && out_blocked) |=> $stable(rsp_start_ff))
      else $error("pending result overwritten");

endmodule

>>> tb/ohlc_bar_aggregator_tb.sv
`timescale 1ns / 100ps

module ohlc_bar_aggregator_tb;
   import ohlc_pkg::*;

   localparam logic [63:0] TS_MASK   = 64'h0000_FFFF_FFFF_FFFF;
   localparam int          IDLE_WAIT = 64;
   localparam int          DRAIN_MAX = 20000;
   localparam int          HOLD_LEN  = 600;
   localparam int          PHASE_LEN = 236;
   localparam int          PHASE_CNT = 7;

   typedef struct packed {
      logic [TimeW-1:0]  start;
      logic [PriceW-1:0] open;
      logic [PriceW-1:0] high;
      logic [PriceW-1:0] low;
      logic [PriceW-1:0] close;
      logic [SumW-1:0]   total;
      logic [CountW-1:0] count;
   } bar_rec_type;

   // Tracks the open bar and queues every bar the block must seal
   class bar_scoreboard;
      logic [DurW-1:0] duration;
      bit              is_open;
      bar_rec_type     cur;
      bar_rec_type     due_q[$];
      int unsigned     mismatches;
      int unsigned     bars_seen;
      int unsigned     trades_seen;
      int unsigned     flushes_seen;

      function new();
         duration     = DUR_RESET;
         is_open      = 1'b0;
         cur          = '0;
         mismatches   = 0;
         bars_seen    = 0;
         trades_seen  = 0;
         flushes_seen = 0;
      endfunction

      function void set_duration(logic [DurW-1:0] d);
         duration = d;
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction

      // Advance the open bar by one accepted request
      function void note_request(logic [CmdW-1:0] cmd, logic [PriceW-1:0] price,
                                 logic [TimeW-1:0] stamp);
         logic [TimeW-1:0] span;
         logic [TimeW-1:0] aligned;
         logic [SumW:0]    wide_sum;
         if (cmd == CMD_FLUSH) begin
            flushes_seen++;
            if (is_open) begin
               due_q.push_back(cur);
               is_open = 1'b0;
               cur     = '0;
            end
            return;
         end
         trades_seen++;
         span    = (duration == '0) ? TimeW'(1) : TimeW'(duration);
         aligned = stamp - (stamp % span);
         if (is_open && aligned == cur.start) begin
            if (price > cur.high) cur.high = price;
            if (price < cur.low) cur.low = price;
            cur.close = price;
            wide_sum  = {1'b0, cur.total} + (SumW + 1)'(price);
            cur.total = wide_sum[SumW] ? '1 : wide_sum[SumW-1:0];
            if (cur.count != '1) cur.count++;
         end else begin
            // Seal the old bar, if any, and open a fresh one with this trade
            if (is_open) due_q.push_back(cur);
            is_open   = 1'b1;
            cur.start = aligned;
            cur.open  = price;
            cur.high  = price;
            cur.low   = price;
            cur.close = price;
            cur.total = SumW'(price);
            cur.count = CountW'(1);
         end
      endfunction

      // Compare one sealed bar with the oldest one due
      function void check_bar(bar_rec_type got);
         bar_rec_type want;
         bit          bad;
         bars_seen++;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected bar: start %h open %h count %0d",
                        $realtime, got.start, got.open, got.count);
            return;
         end
         want = due_q.pop_front();
         bad  = (got != want);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] bar mismatch:", $realtime);
               if (got.start != want.start)
                  $display("   bar_start   exp %h got %h", want.start, got.start);
               if (got.open != want.open)
                  $display("   open_price  exp %h got %h", want.open, got.open);
               if (got.high != want.high)
                  $display("   high_price  exp %h got %h", want.high, got.high);
               if (got.low != want.low)
                  $display("   low_price   exp %h got %h", want.low, got.low);
               if (got.close != want.close)
                  $display("   close_price exp %h got %h", want.close, got.close);
               if (got.total != want.total)
                  $display("   price_total exp %h got %h", want.total, got.total);
               if (got.count != want.count)
                  $display("   trades      exp %0d got %0d", want.count, got.count);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [DurW-1:0] csr_wr_data;

   ohlc_req_if req_bus ();
   ohlc_rsp_if rsp_bus ();

   bar_scoreboard bars = new();

   bit          gaps_on  = 1'b1;
   bit          rsp_hold = 1'b0;
   int unsigned rsp_wait = 0;

   ohlc_bar_aggregator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Drive result ready: hold low during a hold-off or a drawn wait
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Check every accepted bar and draw the wait before the next one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         bars.check_bar('{start: rsp_bus.bar_start, open: rsp_bus.open_price,
                          high: rsp_bus.high_price, low: rsp_bus.low_price,
                          close: rsp_bus.close_price, total: rsp_bus.price_total,
                          count: rsp_bus.trades});
         rsp_wait = gaps_on ? $urandom_range(0, 5) : 0;
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   // Offer one request after a drawn gap and hold it until accepted
   task automatic send_request(logic [CmdW-1:0] cmd, logic [PriceW-1:0] price,
                               logic [TimeW-1:0] stamp);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.price     <= price;
      req_bus.timestamp <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      bars.note_request(cmd, price, stamp);
   endtask

   // Drop valid, wait for every bar due, then let a trade in flight finish
   task automatic drain();
      int unsigned guard;
      guard = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (bars.pending() != 0 && guard < DRAIN_MAX) begin
         @(negedge clock);
         guard++;
      end
      repeat (IDLE_WAIT) @(negedge clock);
   endtask

   task automatic write_duration(logic [DurW-1:0] d);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      bars.set_duration(d);
   endtask

   // Mostly trades walking forward through buckets, with noise and flushes mixed in
   task automatic run_random_phase(int unsigned n_items, logic [DurW-1:0] dur);
      logic [63:0]       span;
      logic [63:0]       cursor;
      logic [63:0]       step;
      logic [PriceW-1:0] level;
      logic [PriceW-1:0] price;
      logic [TimeW-1:0]  stamp;
      int unsigned       pick;
      span   = (dur == '0) ? 64'd1 : 64'(dur);
      cursor = 64'(bars.cur.start);
      level  = rand48();
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         pick = (i == 0) ? 99 : $urandom_range(0, 99);
         if (pick < 6) begin
            send_request(CMD_FLUSH, rand48(), rand48());
         end else if (pick < 14) begin
            stamp = rand48();
            if (pick < 10) cursor = 64'(stamp);
            send_request(CMD_TRADE, rand48(), stamp);
         end else begin
            // Stay in the bucket most of the time, else step into a later one
            if (i != 0) begin
               if ($urandom_range(0, 3) != 0)
                  step = 64'($urandom_range(0, 32'(span >> 3)));
               else
                  step = span * 64'($urandom_range(1, 2));
               cursor = (cursor + step) & TS_MASK;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               level = level + PriceW'($urandom_range(0, 2000)) - PriceW'(1000);
               price = level;
            end else if (pick < 8) begin
               price = rand48();
            end else if (pick == 8) begin
               price = '0;
            end else begin
               price = '1;
            end
            send_request(CMD_TRADE, price, cursor[TimeW-1:0]);
         end
      end
   endtask

   initial begin
      logic [DurW-1:0] spans [PHASE_CNT];
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_TRADE;
      req_bus.price        = '0;
      req_bus.timestamp    = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty flush, bucket edges, field extremes, reopen after flush
      gaps_on = 1'b1;
      send_request(CMD_FLUSH, '1, '1);
      send_request(CMD_TRADE, '0, '0);
      send_request(CMD_TRADE, '1, TimeW'(59));
      send_request(CMD_TRADE, PriceW'(5), TimeW'(30));
      send_request(CMD_TRADE, PriceW'(7), TimeW'(60));
      send_request(CMD_FLUSH, '0, '0);
      send_request(CMD_FLUSH, '0, '0);
      send_request(CMD_TRADE, PriceW'(1), TimeW'(10));
      send_request(CMD_TRADE, '1, '1);
      send_request(CMD_TRADE, '0, TimeW'({TimeW{1'b1}} - 1'b1));
      send_request(CMD_TRADE, PriceW'(12345), '1);
      send_request(CMD_TRADE, '1, '0);
      send_request(CMD_TRADE, PriceW'(3), TimeW'(119));
      send_request(CMD_TRADE, PriceW'(4), TimeW'(61));

      // Bucket settings: shortest, zero, longest, then random ones and the reset value
      spans[0] = 32'd1;
      spans[1] = 32'd0;
      spans[2] = 32'hFFFF_FFFF;
      spans[3] = $urandom_range(2, 200);
      spans[4] = $urandom_range(1000, 1000000);
      spans[5] = $urandom();
      spans[6] = DUR_RESET;
      for (int k = 0; k < PHASE_CNT; k++) begin
         drain();
         write_duration(spans[k]);
         if (k == 2) begin
            // Hold off results long enough for the block to back up its input
            fork
               begin
                  @(posedge clock);
                  rsp_hold = 1'b1;
                  repeat (HOLD_LEN) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         run_random_phase(PHASE_LEN, spans[k]);
      end
      send_request(CMD_FLUSH, '0, '0);
      drain();

      $display("Ran %0d trades and %0d flushes over %0d bucket settings.",
               bars.trades_seen, bars.flushes_seen, PHASE_CNT + 1);
      $display("Compared %0d bars, %0d mismatched, %0d never arrived.",
               bars.bars_seen, bars.mismatches, bars.pending());
      if (bars.mismatches == 0 && bars.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // End a hung run
   initial begin
      #8_000_000;
      $display("Timed out with %0d bars outstanding.", bars.pending());
      $display("FAIL");
      $finish;
   end

endmodule
